// ----- hdl/hkl_pkg.sv -----
// ----------------------------------------------------------------------------
// hkl_pkg
// Shared constants, types and the nibble decode for the hex key line decoder.
// ----------------------------------------------------------------------------
package hkl_pkg;

  localparam int KEY_BYTES  = 32;
  localparam int LINE_LEN   = 2 * KEY_BYTES;
  localparam int CNT_W      = $clog2(LINE_LEN + 1);
  localparam int KEY_ADDR_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_A_LESS = 8'd87;  // 'a' - 10

  localparam logic KIND_KEY_BYTE = 1'b0;
  localparam logic KIND_BAD_LEN  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic take;         // input item accepted this cycle
    logic rd_en;        // read both nibble stores at the read index
    logic load_byte;    // load a decoded byte into the output register
    logic load_status;  // load a bad-length status into the output register
  } hkl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_term;      // current character is CR or LF
    logic line_full;
    logic line_empty;
    logic last_idx;     // read index points at the final key byte
    logic out_free;     // output register can take a new result
  } hkl_status_t;

  // Signed 8-bit char: negatives count as <= '9'. Only the low 8 bits matter.
  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    logic [7:0] r;
    if (c[7] || (c <= CH_NINE)) begin
      r = c - CH_ZERO;
    end else begin
      r = c - CH_A_LESS;
    end
    return r;
  endfunction

endpackage

// ----- hdl/hkl_datapath.sv -----
// ----------------------------------------------------------------------------
// hkl_datapath
// Character count, nibble stores (high and low halves) and output register.
// ----------------------------------------------------------------------------
module hkl_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          character,
  input  hkl_pkg::hkl_cmd_t   cmd,
  output hkl_pkg::hkl_status_t status,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                kind,
  output logic [7:0]          key_byte,
  output logic                last
);

  logic [hkl_pkg::CNT_W-1:0]      count;
  logic [hkl_pkg::KEY_ADDR_W-1:0] rd_idx;
  logic [7:0]                     mem_hi [hkl_pkg::KEY_BYTES];
  logic [7:0]                     mem_lo [hkl_pkg::KEY_BYTES];
  logic [7:0]                     rd_hi;
  logic [7:0]                     rd_lo;
  logic [7:0]                     nib;
  logic [hkl_pkg::KEY_ADDR_W-1:0] wr_addr;
  logic                           is_term;
  logic                           line_full;
  logic                           store_en;

  assign is_term   = (character == hkl_pkg::CH_CR) || (character == hkl_pkg::CH_LF);
  assign line_full = (count == hkl_pkg::CNT_W'(hkl_pkg::LINE_LEN));
  assign store_en  = cmd.take && !is_term && !line_full;
  assign nib       = hkl_pkg::nibble_of(character);
  assign wr_addr   = count[hkl_pkg::KEY_ADDR_W:1];

  assign status.is_term    = is_term;
  assign status.line_full  = line_full;
  assign status.line_empty = (count == '0);
  assign status.last_idx   = (rd_idx == hkl_pkg::KEY_ADDR_W'(hkl_pkg::KEY_BYTES - 1));
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.take && is_term) begin
      count <= '0;
    end else if (store_en) begin
      count <= count + 1'b1;
    end
  end

  // even characters are high nibbles, odd ones low nibbles
  always_ff @(posedge clk) begin
    if (store_en && !count[0]) begin
      mem_hi[wr_addr] <= nib;
    end
    if (store_en && count[0]) begin
      mem_lo[wr_addr] <= nib;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_hi <= mem_hi[rd_idx];
      rd_lo <= mem_lo[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.take) begin
      rd_idx <= '0;
    end else if (cmd.load_byte) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_byte || cmd.load_status) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      kind     <= hkl_pkg::KIND_KEY_BYTE;
      key_byte <= {rd_hi[3:0], 4'b0000} | rd_lo;
      last     <= status.last_idx;
    end else if (cmd.load_status) begin
      kind     <= hkl_pkg::KIND_BAD_LEN;
      key_byte <= 8'h00;
      last     <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= hkl_pkg::CNT_W'(hkl_pkg::LINE_LEN))
    else $error("character count beyond line length");

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_byte && cmd.load_status))
    else $error("byte and status loaded together");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_byte || cmd.load_status) |-> (!out_valid || out_ready))
    else $error("output register overwritten while holding a result");

  a_no_store_in_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en || cmd.load_byte) |-> !cmd.take)
    else $error("input taken during an emit run");
`endif

endmodule

// ----- hdl/hkl_ctrl.sv -----
// ----------------------------------------------------------------------------
// hkl_ctrl
// Sequencer: collects characters, then walks the key bytes or emits a status.
// ----------------------------------------------------------------------------
module hkl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hkl_pkg::hkl_status_t status,
  output hkl_pkg::hkl_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_LOAD   = 4'b0100,
    S_STATUS = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    cmd.take        = 1'b0;
    cmd.rd_en       = 1'b0;
    cmd.load_byte   = 1'b0;
    cmd.load_status = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && status.is_term) begin
          if (status.line_full) begin
            state_next = S_READ;
          end else if (!status.line_empty) begin
            state_next = S_STATUS;
          end
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.load_byte = 1'b1;
          state_next    = status.last_idx ? S_IDLE : S_READ;
        end
      end
      S_STATUS: begin
        if (status.out_free) begin
          cmd.load_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/hex_key_line_decoder.sv -----
// ----------------------------------------------------------------------------
// hex_key_line_decoder
// Collects a line of hex text and emits the decoded key bytes.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while a line is collected; each is
// decoded to a nibble on entry and written to one of two 32-entry stores.
// CR or LF ends the line: with all 2*KEY_BYTES characters held the block
// emits KEY_BYTES bytes, the last one flagged; with a partial line it emits
// one bad-length status; an empty line gives nothing. During an emit run
// input is held off; each byte goes through a store read (S_READ) and then
// an output load (S_LOAD), which waits while the output register is full. A
// status is loaded in S_STATUS once the output register is free. Excess
// characters beyond the line length are dropped. A result can wait in the
// output register while the next line is being received.
module hex_key_line_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] character,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] key_byte,
  output logic       last
);

  hkl_pkg::hkl_cmd_t    cmd;
  hkl_pkg::hkl_status_t status;

  hkl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hkl_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .character (character),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .kind      (kind),
    .key_byte  (key_byte),
    .last      (last)
  );

endmodule
